@@ src/xcrd_pkg.sv @@
// Package for the XOR-checked response deframer.
// Holds the transfer item types, frame constants and error codes.
// No dependencies.
`timescale 1ns / 1ps

package xcrd_pkg;

    localparam int TRANSACTION_BYTES = 15;
    localparam int POS_W = 4;
    localparam int LEN_SUM_W = 9;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] MIN_LENGTH = 8'd3;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_NO_HEADER = 3'd1;
    localparam logic [2:0] ERR_HEADER_LATE = 3'd2;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [2:0] error_kind;
        logic [7:0] data_value;
    } t_out_item;

endpackage

@@ src/xor_checked_response_deframer_top.sv @@
// Top level of the XOR-checked response deframer.
// Depends on xcrd_pkg for item types, constants and error codes.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one received byte
//   per transfer; first_byte marks the start of a transaction and clears the
//   parser, abandoning any transaction that has no verdict yet.
//   Output channel (o_out_valid / i_out_stall / o_out) carries one verdict per
//   transaction: ok, error_kind and data_value (zero unless ok).
//   Each byte is parsed in the cycle it is accepted, by a compare and an XOR;
//   its verdict is registered in the result register, or in the skid register
//   while the receiver stalls. One byte per cycle flows while o_in_stall is low.
//   A two-entry output (result register plus skid register) lets input bytes
//   keep flowing while a verdict waits; o_in_stall rises only when both
//   entries are full, i.e. after the receiver has stalled for two verdicts.
//   Reset (synchronous, active low) empties the output and returns the
//   parser to header hunt at position zero; the first byte after reset is
//   taken as position zero even without the mark.
`timescale 1ns / 1ps

module xor_checked_response_deframer_top
    import xcrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_PAYLOAD
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_hdr_pos, n_hdr_pos;
    logic [POS_W-1:0] r_cs_pos, n_cs_pos;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_cap, n_cap;
    logic             r_verdict, n_verdict;

    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic             r_skid_valid, n_skid_valid;
    t_out_item        r_skid, n_skid;

    logic             w_accept;
    logic             w_emit;
    t_out_item        w_res;

    t_phase           w_phase;
    logic [POS_W-1:0] w_pos;
    logic             w_verdict;
    logic [LEN_SUM_W-1:0] w_cs_sum;
    logic [POS_W:0]   w_cap_pos;

    assign w_accept = i_in_valid && !r_skid_valid;

    always_comb begin
        w_phase   = i_in.first_byte ? PH_HUNT : r_phase;
        w_pos     = i_in.first_byte ? '0 : r_pos;
        w_verdict = i_in.first_byte ? 1'b0 : r_verdict;
        w_cs_sum  = LEN_SUM_W'(r_hdr_pos) + LEN_SUM_W'(i_in.rx_byte) + LEN_SUM_W'(2);
        w_cap_pos = {1'b0, r_hdr_pos} + (POS_W+1)'(4);

        n_phase   = w_phase;
        n_pos     = (w_pos == POS_MAX) ? POS_MAX : w_pos + POS_W'(1);
        n_hdr_pos = r_hdr_pos;
        n_cs_pos  = r_cs_pos;
        n_xor     = r_xor;
        n_cap     = r_cap;
        n_verdict = w_verdict;
        w_emit    = 1'b0;
        w_res     = '{ok: 1'b0, error_kind: ERR_NONE, data_value: 8'd0};

        if (!w_verdict) begin
            unique case (w_phase)
                PH_HUNT: begin
                    if (i_in.rx_byte == HEADER_BYTE) begin
                        if ({1'b0, w_pos} + (POS_W+1)'(3) >= (POS_W+1)'(TRANSACTION_BYTES)) begin
                            w_emit = 1'b1;
                            w_res.error_kind = ERR_HEADER_LATE;
                        end else begin
                            n_hdr_pos = w_pos;
                            n_phase   = PH_LENGTH;
                        end
                    end else if ({1'b0, w_pos} + (POS_W+1)'(1)
                                 >= (POS_W+1)'(TRANSACTION_BYTES)) begin
                        w_emit = 1'b1;
                        w_res.error_kind = ERR_NO_HEADER;
                    end
                end
                PH_LENGTH: begin
                    if (i_in.rx_byte < MIN_LENGTH
                        || w_cs_sum >= LEN_SUM_W'(TRANSACTION_BYTES)) begin
                        w_emit = 1'b1;
                        w_res.error_kind = ERR_BAD_LENGTH;
                    end else begin
                        n_xor    = i_in.rx_byte;
                        n_cs_pos = w_cs_sum[POS_W-1:0];
                        n_phase  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (w_pos == r_cs_pos) begin
                        w_emit = 1'b1;
                        if (r_xor == i_in.rx_byte) begin
                            w_res.ok = 1'b1;
                            w_res.data_value = r_cap;
                        end else begin
                            w_res.error_kind = ERR_CHECKSUM;
                        end
                    end else begin
                        n_xor = r_xor ^ i_in.rx_byte;
                        if ({1'b0, w_pos} == w_cap_pos) begin
                            n_cap = i_in.rx_byte;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
        if (w_emit) begin
            n_verdict = 1'b1;
        end
    end

    // Result register with skid stage behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_accept && w_emit;
                n_out       = w_res;
            end
        end else if (w_accept && w_emit) begin
            n_skid_valid = 1'b1;
            n_skid       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_pos        <= '0;
            r_verdict    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase   <= n_phase;
                r_pos     <= n_pos;
                r_verdict <= n_verdict;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr_pos <= n_hdr_pos;
            r_cs_pos  <= n_cs_pos;
            r_xor     <= n_xor;
            r_cap     <= n_cap;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_verdict_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit) |=> r_verdict)
        else $error("verdict given but not recorded");

    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ok) |-> (o_out.error_kind == ERR_NONE))
        else $error("good frame carries an error code");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.ok) |-> (o_out.data_value == 8'd0
            && o_out.error_kind != ERR_NONE))
        else $error("error verdict with value or without code");

    a_cs_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> ({1'b0, r_cs_pos} >= {1'b0, r_hdr_pos} + (POS_W+1)'(5)))
        else $error("checksum position ahead of captured byte");

endmodule
